[hdl/olc_pkg.sv]
// ----------------------------------------------------------------------------
// olc_pkg: shared types and codes for the ordered list with cursor
// Request and response transaction types, request and status codes, the
// controller state type and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package olc_pkg;

	localparam int DEPTH_DEF       = 64;
	localparam int HANDLE_BITS_DEF = 16;

	localparam int REQ_W    = 3;
	localparam int HANDLE_W = 16;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_HEAD    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_NEXT    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DEL_CUR = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DEL_KEY = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOCUR = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]    req_type;
		logic [HANDLE_W-1:0] handle;
	} req_t;

	typedef struct packed {
		logic                cursor_present;
		logic [HANDLE_W-1:0] cursor_handle;
		logic [COUNT_W-1:0]  entry_count;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_READ,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic walk;
		logic read;
	} cmd_t;

	typedef struct packed {
		logic walk_req;
		logic walk_done;
	} stat_t;

endpackage

[hdl/ordered_list_with_cursor_unit.sv]
// ----------------------------------------------------------------------------
// ordered_list_with_cursor_unit: ordered handle list with a cursor
// Keeps up to DEPTH handles in append order, with a cursor that walks them.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request transaction on req; it is taken at the rising
//   edge where start is high and busy is low. busy stays high until the
//   response has been shown. The response transaction appears on rsp for
//   exactly one cycle with done high; the receiver must take it then, as it
//   cannot stall the block.
// Sequence:
//   Append, cursor to head, advance, unused codes and a delete with no
//   cursor step through execute, cursor read and response. Delete at
//   cursor walks the entries behind the cursor and delete by key walks the
//   whole list, one RAM read and at most one write per cycle, between
//   execute and cursor read; a walk may read no entry at all. The entry
//   RAM, with one write port and one read port, sets that pace.
// Reset:
//   arst_n clears the count and the cursor at once; the entry RAM is not
//   cleared and needs no clearing pass, as only entries below the count are
//   ever used.
// ----------------------------------------------------------------------------
module ordered_list_with_cursor_unit #(
	parameter int DEPTH       = olc_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = olc_pkg::HANDLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  olc_pkg::req_t req,
	output logic          done,
	output olc_pkg::rsp_t rsp
);

	// Command and status groups between sequencer and datapath
	olc_pkg::cmd_t  cmd;
	olc_pkg::stat_t stat;

	// Sequence each transaction: load, execute, walk, read cursor, respond
	olc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd),
		.stat  (stat)
	);

	// Hold the list, advance the cursor and drop deleted entries
	olc_datapath #(
		.DEPTH      (DEPTH),
		.HANDLE_BITS(HANDLE_BITS)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cmd   (cmd),
		.stat  (stat)
	);

endmodule

[hdl/olc_ram.sv]
// ----------------------------------------------------------------------------
// olc_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/olc_ctrl.sv]
// ----------------------------------------------------------------------------
// olc_ctrl: request sequencer
// Steps each request through execute, optional compaction walk, cursor read
// and response.
// ----------------------------------------------------------------------------
module olc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output olc_pkg::cmd_t  cmd,
	input  olc_pkg::stat_t stat
);

	olc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		busy     = 1'b1;
		done     = 1'b0;
		unique case (state_q)
			olc_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = olc_pkg::S_EXEC;
				end
			end
			olc_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.walk_req ? olc_pkg::S_WALK : olc_pkg::S_READ;
			end
			olc_pkg::S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_done) begin
					state_d = olc_pkg::S_READ;
				end
			end
			olc_pkg::S_READ: begin
				cmd.read = 1'b1;
				state_d  = olc_pkg::S_RESP;
			end
			olc_pkg::S_RESP: begin
				done    = 1'b1;
				state_d = olc_pkg::S_IDLE;
			end
			default: begin
				state_d = olc_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[hdl/olc_datapath.sv]
// ----------------------------------------------------------------------------
// olc_datapath: list storage, count, cursor and compaction walk
// Holds the entry RAM and the list state; at most one read and at most one
// write to the RAM each cycle.
// ----------------------------------------------------------------------------
module olc_datapath #(
	parameter int DEPTH       = olc_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = olc_pkg::HANDLE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  olc_pkg::req_t  req,
	output olc_pkg::rsp_t  rsp,
	input  olc_pkg::cmd_t  cmd,
	output olc_pkg::stat_t stat
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	logic [olc_pkg::REQ_W-1:0]    req_type_q;
	logic [HANDLE_BITS-1:0]       key_q;
	logic [CNT_W-1:0]             count_q;
	logic [ADDR_W-1:0]            idx_q;
	logic                         cv_q;
	logic [olc_pkg::STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]             rd_q;
	logic [CNT_W-1:0]             wr_q;
	logic                         keep_all_q;
	logic                         pend_s1;

	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [HANDLE_BITS-1:0] ram_wdata;
	logic                   ram_re;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [HANDLE_BITS-1:0] ram_rdata;

	logic [CNT_W-1:0] idx_ext;
	logic [CNT_W-1:0] idx_inc;
	logic             rd_more;
	logic             keep;

	assign idx_ext = CNT_W'(idx_q);
	assign idx_inc = idx_ext + CNT_W'(1);
	assign rd_more = rd_q < count_q;
	assign keep    = keep_all_q || (ram_rdata != key_q);

	assign stat.walk_req  = ((req_type_q == olc_pkg::REQ_DEL_CUR) && cv_q)
	                        || (req_type_q == olc_pkg::REQ_DEL_KEY);
	assign stat.walk_done = !rd_more && !pend_s1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_q[ADDR_W-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = rd_q[ADDR_W-1:0];
		if (cmd.exec && (req_type_q == olc_pkg::REQ_APPEND)
		    && (count_q < CNT_W'(DEPTH))) begin
			ram_we    = 1'b1;
			ram_waddr = count_q[ADDR_W-1:0];
			ram_wdata = key_q;
		end
		if (cmd.walk) begin
			ram_re = rd_more;
			ram_we = pend_s1 && keep;
		end
		if (cmd.read) begin
			ram_re    = 1'b1;
			ram_raddr = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_type_q <= olc_pkg::REQ_APPEND;
			key_q      <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			cv_q       <= 1'b0;
			status_q   <= olc_pkg::ST_OK;
			rd_q       <= '0;
			wr_q       <= '0;
			keep_all_q <= 1'b0;
			pend_s1    <= 1'b0;
		end else begin
			if (cmd.load) begin
				req_type_q <= req.req_type;
				key_q      <= HANDLE_BITS'(req.handle);
				status_q   <= olc_pkg::ST_OK;
			end
			if (cmd.exec) begin
				pend_s1 <= 1'b0;
				unique case (req_type_q)
					olc_pkg::REQ_APPEND: begin
						if (count_q >= CNT_W'(DEPTH)) begin
							status_q <= olc_pkg::ST_FULL;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					olc_pkg::REQ_HEAD: begin
						idx_q <= '0;
						cv_q  <= (count_q != '0);
					end
					olc_pkg::REQ_NEXT: begin
						if (cv_q) begin
							if (idx_inc >= count_q) begin
								cv_q  <= 1'b0;
								idx_q <= '0;
							end else begin
								idx_q <= idx_inc[ADDR_W-1:0];
							end
						end
					end
					olc_pkg::REQ_DEL_CUR: begin
						if (!cv_q) begin
							status_q <= olc_pkg::ST_NOCUR;
						end
						rd_q       <= idx_inc;
						wr_q       <= idx_ext;
						keep_all_q <= 1'b1;
					end
					olc_pkg::REQ_DEL_KEY: begin
						rd_q       <= '0;
						wr_q       <= '0;
						keep_all_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.walk) begin
				pend_s1 <= rd_more;
				if (rd_more) begin
					rd_q <= rd_q + CNT_W'(1);
				end
				if (pend_s1 && keep) begin
					wr_q <= wr_q + CNT_W'(1);
				end
				if (stat.walk_done) begin
					count_q <= wr_q;
					if (!keep_all_q || (idx_ext >= wr_q)) begin
						cv_q  <= 1'b0;
						idx_q <= '0;
					end
				end
			end
		end
	end

	olc_ram #(
		.WIDTH(HANDLE_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rsp.cursor_present = cv_q;
	assign rsp.cursor_handle  = cv_q ? olc_pkg::HANDLE_W'(ram_rdata) : '0;
	assign rsp.entry_count    = olc_pkg::COUNT_W'(count_q);
	assign rsp.status         = status_q;

endmodule

[tb/sv/ordered_list_with_cursor_checker.sv]
// ----------------------------------------------------------------------------
// ordered_list_with_cursor_checker: response checker for the handle list
// Watches the request and response channels of the list unit. It mirrors the
// list and cursor, predicts the response to each accepted request transaction
// and compares every response, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ordered_list_with_cursor_checker #(
	parameter int DEPTH = olc_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  olc_pkg::req_t req,
	input  logic          done,
	input  olc_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending,
	output int            results_checked,
	output int            appends_dropped,
	output int            empty_cursor_deletes,
	output int            peak_entries
);

	import olc_pkg::*;

	logic [HANDLE_W-1:0] held [DEPTH];
	int unsigned         n_held;
	int unsigned         cur_at;
	bit                  cur_on;

	rsp_t                expected_rsp [$];
	rsp_t                want;
	bit                  bad;

	// Apply one request to the mirrored list and return the response it gives.
	function automatic rsp_t apply_list_request(input req_t r);
		rsp_t        o;
		int unsigned rd;
		int unsigned wr;
		o = '0;
		o.status = ST_OK;
		case (r.req_type)
			REQ_APPEND: begin
				if (n_held >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					held[n_held] = r.handle;
					n_held++;
				end
			end
			REQ_HEAD: begin
				cur_at = 0;
				cur_on = (n_held > 0);
			end
			REQ_NEXT: begin
				if (cur_on) begin
					cur_at++;
					if (cur_at >= n_held) begin
						cur_on = 1'b0;
						cur_at = 0;
					end
				end
			end
			REQ_DEL_CUR: begin
				if (!cur_on || cur_at >= n_held) begin
					cur_on = 1'b0;
					o.status = ST_NOCUR;
				end else begin
					for (rd = cur_at; rd + 1 < n_held; rd++)
						held[rd] = held[rd + 1];
					n_held--;
					if (cur_at >= n_held) begin
						cur_on = 1'b0;
						cur_at = 0;
					end
				end
			end
			REQ_DEL_KEY: begin
				wr = 0;
				for (rd = 0; rd < n_held; rd++) begin
					if (held[rd] != r.handle) begin
						held[wr] = held[rd];
						wr++;
					end
				end
				n_held = wr;
				cur_at = 0;
				cur_on = 1'b0;
			end
			default: begin
			end
		endcase
		o.cursor_present = cur_on;
		o.cursor_handle  = (cur_on && cur_at < n_held) ? held[cur_at] : '0;
		o.entry_count    = COUNT_W'(n_held);
		return o;
	endfunction

	function automatic bit field_differs(input string name,
	                                     input logic [HANDLE_W-1:0] want_v,
	                                     input logic [HANDLE_W-1:0] got_v);
		if (got_v === want_v)
			return 1'b0;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
		return 1'b1;
	endfunction

	// Compare first, then predict: a response never belongs to the request
	// accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_held = 0;
			cur_at = 0;
			cur_on = 1'b0;
			expected_rsp.delete();
			fail_count = 0;
			results_checked = 0;
			appends_dropped = 0;
			empty_cursor_deletes = 0;
			peak_entries = 0;
		end else begin
			if (done) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: response with none expected, actual %0h", $time, rsp);
					fail_count++;
				end else begin
					want = expected_rsp.pop_front();
					bad = 1'b0;
					bad |= field_differs("cursor_present",
					                     HANDLE_W'(want.cursor_present),
					                     HANDLE_W'(rsp.cursor_present));
					bad |= field_differs("cursor_handle", want.cursor_handle,
					                     rsp.cursor_handle);
					bad |= field_differs("entry_count", HANDLE_W'(want.entry_count),
					                     HANDLE_W'(rsp.entry_count));
					bad |= field_differs("status", HANDLE_W'(want.status),
					                     HANDLE_W'(rsp.status));
					if (bad)
						fail_count++;
					results_checked++;
				end
			end
			if (start && !busy) begin
				want = apply_list_request(req);
				if (want.status == ST_FULL)
					appends_dropped++;
				if (want.status == ST_NOCUR)
					empty_cursor_deletes++;
				if (n_held > peak_entries)
					peak_entries = n_held;
				expected_rsp.push_back(want);
			end
		end
		pending <= expected_rsp.size();
	end

endmodule

[tb/sv/ordered_list_with_cursor_unit_test.sv]
// ----------------------------------------------------------------------------
// ordered_list_with_cursor_unit_test: top level of the list unit testbench
// Drives request transactions into the handle list: a directed opening over
// the corner cases, then random bursts that grow, walk and shrink the list.
// A checker beside the block predicts and compares every response; this top
// only makes stimulus, guards against a hang and gives the verdict.
// ----------------------------------------------------------------------------
module ordered_list_with_cursor_unit_test;

	import olc_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	// Count of list requests to send; unused codes do not count.
	localparam int ITEMS = 1650;
	// Longest quiet spell: a full walk of the list plus the longest idle gap,
	// taken many times over.
	localparam int QUIET_LIMIT = 20 * (2 * DEPTH + 16);

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	int   fail_count;
	int   pending;
	int   results_checked;
	int   appends_dropped;
	int   empty_cursor_deletes;
	int   peak_entries;

	int   sent = 0;

	ordered_list_with_cursor_unit #(
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS_DEF)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	ordered_list_with_cursor_checker #(
		.DEPTH (DEPTH)
	) i_checker (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (start),
		.busy                 (busy),
		.req                  (req),
		.done                 (done),
		.rsp                  (rsp),
		.fail_count           (fail_count),
		.pending              (pending),
		.results_checked      (results_checked),
		.appends_dropped      (appends_dropped),
		.empty_cursor_deletes (empty_cursor_deletes),
		.peak_entries         (peak_entries)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Offer one request transaction and hold it until the block takes it.
	// Afterwards, now and then, drop start for a gap of random length so that
	// the next request lands on every phase of the block's work. Keep a calm
	// stretch in the middle of the run with no gaps at all.
	task automatic send_request(input logic [REQ_W-1:0] kind,
	                            input logic [HANDLE_W-1:0] h);
		req_t r;
		r.req_type = kind;
		r.handle   = h;
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (kind <= REQ_DEL_KEY)
			sent++;
		if ((sent < 700 || sent >= 1000) && $urandom_range(99) < 10) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Draw mostly from a small pool so that duplicates build up and deletes
	// by key find matches; the rest are fully random so every bit toggles.
	function automatic logic [HANDLE_W-1:0] pick_handle();
		if ($urandom_range(99) < 40)
			return HANDLE_W'($urandom_range(0, 65535));
		case ($urandom_range(5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h0001;
			3:       return 16'h8000;
			4:       return 16'hA5A5;
			default: return 16'h5A5A;
		endcase
	endfunction

	// Hang guard: end the run if nothing is accepted on either side for too
	// long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		int                  mode;
		int                  len;
		int                  step;
		int                  roll;
		logic [REQ_W-1:0]    kind;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. Start with the empty list: advance and delete
		// with no cursor, head and delete by key on nothing, unused codes.
		send_request(REQ_NEXT, 16'h0000);
		send_request(REQ_DEL_CUR, 16'hFFFF);
		send_request(REQ_HEAD, 16'h0000);
		send_request(REQ_DEL_KEY, 16'h0000);
		send_request(3'd5, 16'hFFFF);
		send_request(3'd6, 16'h0000);
		send_request(3'd7, 16'hFFFF);
		// Append the handle extremes while the cursor is empty; it must stay so.
		send_request(REQ_APPEND, 16'h0000);
		send_request(REQ_APPEND, 16'hFFFF);
		send_request(REQ_APPEND, 16'h1234);
		send_request(REQ_APPEND, 16'hFFFF);
		send_request(REQ_APPEND, 16'h0000);
		// Walk in, delete in the middle and check the cursor moves on.
		send_request(REQ_HEAD, 16'h0000);
		send_request(REQ_NEXT, 16'h0000);
		send_request(REQ_DEL_CUR, 16'h0000);
		send_request(REQ_NEXT, 16'h0000);
		send_request(REQ_NEXT, 16'h0000);
		// Delete the last entry: the cursor empties, and a second delete fails.
		send_request(REQ_DEL_CUR, 16'h0000);
		send_request(REQ_DEL_CUR, 16'h0000);
		// Advance off the end of the list.
		send_request(REQ_HEAD, 16'h0000);
		send_request(REQ_NEXT, 16'h0000);
		send_request(REQ_NEXT, 16'h0000);
		send_request(REQ_NEXT, 16'h0000);
		// Delete by key with a match, then with none.
		send_request(REQ_DEL_KEY, 16'hFFFF);
		send_request(REQ_DEL_KEY, 16'hABCD);

		// Random bursts. Growth bursts fill the list up to and past full,
		// walk bursts move the cursor about and delete under it, shrink
		// bursts empty it again, and noise bursts send anything at all.
		while (sent < ITEMS) begin
			mode = $urandom_range(9);
			len  = (mode < 4) ? $urandom_range(20, 90) : $urandom_range(8, 40);
			for (step = 0; step < len; step++) begin
				roll = $urandom_range(99);
				if (mode < 4) begin
					if (roll < 85)
						kind = REQ_APPEND;
					else
						kind = REQ_W'($urandom_range(1, 4));
				end else if (mode < 7) begin
					if (step == 0 || roll < 10)
						kind = REQ_HEAD;
					else if (roll < 60)
						kind = REQ_NEXT;
					else if (roll < 90)
						kind = REQ_DEL_CUR;
					else
						kind = REQ_APPEND;
				end else if (mode < 9) begin
					if (roll < 40)
						kind = REQ_DEL_CUR;
					else if (roll < 70)
						kind = REQ_DEL_KEY;
					else if (roll < 90)
						kind = REQ_HEAD;
					else
						kind = REQ_NEXT;
				end else begin
					kind = REQ_W'($urandom_range(7));
				end
				send_request(kind, pick_handle());
			end
		end

		// Drain: drop start, let the checker count the last transaction,
		// wait for the last response, then allow a full list walk for
		// anything stray.
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("sent %0d list requests, checked %0d responses, peak of %0d entries",
		         sent, results_checked, peak_entries);
		$display("appends dropped on a full list: %0d, deletes with no cursor: %0d",
		         appends_dropped, empty_cursor_deletes);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
